@@ sv/xsw_pkg.sv @@
// Shared types and constants for the XOR swizzle tile address map.
// Used by xsw_map, xsw_div_stage and the top level.
`default_nettype none

package xsw_pkg;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 12;
    localparam int COLS_W     = 13;
    localparam int LIN_W      = 24;
    localparam int TGT_W      = 28;
    localparam int REM_W      = 12;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = TGT_W / DIV_STEPS;
    localparam int MAX_COLS   = 4096;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRANULE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE       = 3'd4;

    // Reset values
    localparam logic [12:0] RST_NUM_COLS   = 13'd64;
    localparam logic [1:0]  RST_ELEM_BYTES = 2'd1;
    localparam logic [2:0]  RST_GRANULE    = 3'd4;
    localparam logic [3:0]  RST_STRIDE     = 4'd8;
    localparam logic [3:0]  RST_LINE       = 4'd8;

    typedef struct packed {
        logic [COLS_W-1:0] cols;   // clamped column count, 1 .. MAX_COLS
        logic [1:0]        ebl;
        logic [2:0]        gran;
        logic [3:0]        stride;
        logic [3:0]        line;
    } cfg_t;

    // Long division state carried through the divider stages
    typedef struct packed {
        logic [TGT_W-1:0] dvd;
        logic [REM_W-1:0] rem;
        logic [ROW_W-1:0] quo;
        logic             ovf;   // quotient has grown past ROW_W bits
        logic             err;
    } div_t;

endpackage

`default_nettype wire

@@ sv/xor_swizzle_tile_address_map_core.sv @@
// XOR swizzle tile address map: row/column in, swizzled row/column out.
// Depends on xsw_pkg, xsw_map and xsw_div_stage.
//
// Usage:
//   s_axis carries one element position per word; m_axis returns its swizzled
//   row and column, with tuser set when the stride is below the granularity
//   (row and column are then zero). Words leave in the order they arrive.
//   Configuration is written through cfg_we/cfg_index/cfg_data by the user
//   only while no word is in flight; the block does not enforce this.
//   Indexes past the last register are ignored.
// Pipeline: 2 mapping stages, 7 divider stages, then the output register.
// Throughput: one word per cycle unless stalled. The element index is divided
//   by the column count in a 28-step restoring divider, 4 steps per stage.
// Reset: all stages empty, registers at 64 cols, 2-byte elements, 16-byte
//   granule, 256-byte stride and line.
// Stall: while m_axis_tready is low the output word holds; each stage keeps
//   loading as long as the one after it has room, so bubbles close up and
//   s_axis_tready falls only once every stage is full.
`default_nettype none

module xor_swizzle_tile_address_map_core
    import xsw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,   // row_index, col_index
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // out_row, out_col
    output logic                       m_axis_tuser    // config_error
);

    logic [12:0]       num_cols_reg;
    logic [1:0]        ebl_reg;
    logic [2:0]        gran_reg;
    logic [3:0]        stride_reg;
    logic [3:0]        line_reg;
    logic [COLS_W-1:0] cols_eff;
    cfg_t              cfg;

    div_t              div_data  [0:DIV_STAGES];
    logic              div_valid [0:DIV_STAGES];
    logic              div_ready [0:DIV_STAGES];

    logic              o_valid_reg;
    logic [ROW_W-1:0]  o_row_reg;
    logic [COL_W-1:0]  o_col_reg;
    logic              o_err_reg;
    logic [ROW_W-1:0]  o_row_next;
    logic [COL_W-1:0]  o_col_next;
    logic              out_en;
    div_t              fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= RST_NUM_COLS;
            ebl_reg      <= RST_ELEM_BYTES;
            gran_reg     <= RST_GRANULE;
            stride_reg   <= RST_STRIDE;
            line_reg     <= RST_LINE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_COLS:   num_cols_reg <= cfg_data[12:0];
                REG_ELEM_BYTES: ebl_reg      <= cfg_data[1:0];
                REG_GRANULE:    gran_reg     <= cfg_data[2:0];
                REG_STRIDE:     stride_reg   <= cfg_data[3:0];
                REG_LINE:       line_reg     <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Zero columns act as one; clamp at the largest tile width
    always_comb
    begin
        if (num_cols_reg == '0)
            cols_eff = COLS_W'(1);
        else if (num_cols_reg > COLS_W'(MAX_COLS))
            cols_eff = COLS_W'(MAX_COLS);
        else
            cols_eff = num_cols_reg;
    end

    assign cfg.cols   = cols_eff;
    assign cfg.ebl    = ebl_reg;
    assign cfg.gran   = gran_reg;
    assign cfg.stride = stride_reg;
    assign cfg.line   = line_reg;

    xsw_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .row_index  (s_axis_tdata[11:0]),
        .col_index  (s_axis_tdata[23:12]),
        .up_ready   (s_axis_tready),
        .down_ready (div_ready[0]),
        .out_valid  (div_valid[0]),
        .out_data   (div_data[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        xsw_div_stage u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .cols       (cols_eff),
            .in_valid   (div_valid[k]),
            .in_data    (div_data[k]),
            .up_ready   (div_ready[k]),
            .down_ready (div_ready[k+1]),
            .out_valid  (div_valid[k+1]),
            .out_data   (div_data[k+1])
        );
    end

    assign out_en                = !o_valid_reg || m_axis_tready;
    assign div_ready[DIV_STAGES] = out_en;
    assign fin                   = div_data[DIV_STAGES];

    // Saturate the row; drop both fields on a bad stride/granule pair
    always_comb
    begin
        if (fin.err)
        begin
            o_row_next = '0;
            o_col_next = '0;
        end
        else
        begin
            o_row_next = fin.ovf ? '1 : fin.quo;
            o_col_next = fin.rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (out_en)
            o_valid_reg <= div_valid[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (out_en && div_valid[DIV_STAGES])
        begin
            o_row_reg <= o_row_next;
            o_col_reg <= o_col_next;
            o_err_reg <= fin.err;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {o_col_reg, o_row_reg};
    assign m_axis_tuser  = o_err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("config_error word carries nonzero fields");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && div_valid[DIV_STAGES]
            |-> !div_ready[DIV_STAGES-1])
        else $error("last divider stage overwritten during stall");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> COLS_W'(m_axis_tdata[23:12]) < cols_eff)
        else $error("column not below column count");

endmodule

`default_nettype wire

@@ sv/xsw_map.sv @@
// Front of the pipeline: linear index (multiply-add), then the XOR swizzle.
// Depends on xsw_pkg; feeds the divider chain with a div_t word.
`default_nettype none

module xsw_map
    import xsw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    input  wire logic [ROW_W-1:0] row_index,
    input  wire logic [COL_W-1:0] col_index,
    output logic                  up_ready,
    input  wire logic             down_ready,
    output logic                  out_valid,
    output div_t                  out_data
);

    logic                      a_valid_reg;
    logic [LIN_W-1:0]          a_lin_reg;
    logic                      a_err_reg;
    logic                      b_valid_reg;
    div_t                      b_data_reg;
    logic                      en_a;
    logic                      en_b;
    logic [ROW_W+COLS_W-1:0]   prod;
    logic [ROW_W+COLS_W-1:0]   lin_sum;
    logic [LIN_W-1:0]          a_lin_next;
    logic                      a_err_next;
    logic [TGT_W-1:0]          addr;
    logic [TGT_W-1:0]          line_mask;
    logic [TGT_W-1:0]          gran_mask;
    logic [TGT_W-1:0]          cyc_mask;
    logic [3:0]                cyc_sh;
    logic [TGT_W-1:0]          line_off;
    logic [TGT_W-1:0]          gran_id;
    logic [TGT_W-1:0]          cycle_id;
    logic [TGT_W-1:0]          tgt;
    div_t                      b_data_next;

    assign en_b     = !b_valid_reg || down_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign up_ready = en_a;

    assign prod       = (ROW_W+COLS_W)'(row_index) * (ROW_W+COLS_W)'(cfg.cols);
    assign lin_sum    = prod + (ROW_W+COLS_W)'(col_index);
    assign a_lin_next = lin_sum[LIN_W-1:0];
    assign a_err_next = cfg.stride < {1'b0, cfg.gran};

    always_comb
    begin
        addr      = TGT_W'(a_lin_reg) << cfg.ebl;
        line_mask = (TGT_W'(1) << cfg.line) - TGT_W'(1);
        gran_mask = (TGT_W'(1) << cfg.gran) - TGT_W'(1);
        cyc_sh    = cfg.stride - {1'b0, cfg.gran};
        cyc_mask  = (TGT_W'(1) << cyc_sh) - TGT_W'(1);
        line_off  = addr & line_mask;
        gran_id   = line_off >> cfg.gran;
        cycle_id  = (addr >> cfg.line) & cyc_mask;
        tgt       = (addr & ~line_mask)
                  + ((gran_id ^ cycle_id) << cfg.gran)
                  + (line_off & gran_mask);
        b_data_next     = '0;
        b_data_next.dvd = tgt >> cfg.ebl;
        b_data_next.err = a_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= in_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_lin_reg <= a_lin_next;
            a_err_reg <= a_err_next;
        end
        if (en_b && a_valid_reg)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

@@ sv/xsw_div_stage.sv @@
// One divider stage: DIV_STEPS restoring division steps, then a register.
// Depends on xsw_pkg; chained DIV_STAGES times by the top level.
`default_nettype none

module xsw_div_stage
    import xsw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [COLS_W-1:0] cols,
    input  wire logic              in_valid,
    input  wire div_t              in_data,
    output logic                   up_ready,
    input  wire logic              down_ready,
    output logic                   out_valid,
    output div_t                   out_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [REM_W:0]   rem_sh;
    logic             en;

    assign en       = !valid_reg || down_ready;
    assign up_ready = en;

    always_comb
    begin
        data_next = in_data;
        rem_sh    = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_sh        = {data_next.rem, data_next.dvd[TGT_W-1]};
            data_next.dvd = data_next.dvd << 1;
            data_next.ovf = data_next.ovf | data_next.quo[ROW_W-1];
            if (rem_sh >= cols)
            begin
                data_next.rem = REM_W'(rem_sh - cols);
                data_next.quo = {data_next.quo[ROW_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = rem_sh[REM_W-1:0];
                data_next.quo = {data_next.quo[ROW_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ tb/sv/xor_swizzle_tile_address_map_core_test.sv @@
// Self-checking testbench for xor_swizzle_tile_address_map_core: drives element positions,
// predicts the swizzled row/column for each accepted word and checks every output word.
// Depends on xsw_pkg and the core RTL.
`default_nettype none

module xor_swizzle_tile_address_map_core_test
    import xsw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_WORDS   = 125;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cfg_err;
    } swz_pos_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;   // row_index, col_index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;        // out_row, out_col
    logic                  m_axis_tuser;        // config_error

    // Local copy of the register file
    logic [12:0] tile_cols  = RST_NUM_COLS;
    logic [1:0]  elem_shift = RST_ELEM_BYTES;
    logic [2:0]  gran_shift = RST_GRANULE;
    logic [3:0]  strd_shift = RST_STRIDE;
    logic [3:0]  line_shift = RST_LINE;

    swz_pos_t pending_maps[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       src_idle_pct = 25;
    int       sink_idle_pct = 25;

    xor_swizzle_tile_address_map_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic longint unsigned clamp_cols(logic [12:0] cols);
        longint unsigned c;
        c = 64'(cols);
        if (c == 0)
            c = 1;
        if (c > MAX_COLS)
            c = 64'(MAX_COLS);
        return c;
    endfunction

    function automatic swz_pos_t swizzle_position(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        swz_pos_t        res;
        longint unsigned cols, addr, line_id, line_off, cyc_id, gran_id, gran_off;
        longint unsigned tgt_addr, tgt_lin, orow, ocol;
        int              cyc_bits;
        res = '0;
        if (strd_shift < gran_shift)
        begin
            res.cfg_err = 1'b1;
            return res;
        end
        cols     = clamp_cols(tile_cols);
        cyc_bits = int'(strd_shift) - int'(gran_shift);
        addr     = (longint'(row) * cols + longint'(col)) << elem_shift;
        line_id  = addr >> line_shift;
        line_off = addr & ((64'd1 << line_shift) - 1);
        cyc_id   = line_id & ((64'd1 << cyc_bits) - 1);
        gran_id  = line_off >> gran_shift;
        gran_off = line_off & ((64'd1 << gran_shift) - 1);
        tgt_addr = (line_id << line_shift) + ((gran_id ^ cyc_id) << gran_shift) + gran_off;
        tgt_lin  = tgt_addr >> elem_shift;
        orow     = tgt_lin / cols;
        ocol     = tgt_lin % cols;
        if (orow > 4095)
            orow = 4095;
        res.row = orow[ROW_W-1:0];
        res.col = ocol[COL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare each accepted output word with the oldest prediction
    always @(posedge clk)
    begin
        swz_pos_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_maps.size() == 0)
                report_mismatch("output word with nothing pending");
            else
            begin
                want = pending_maps.pop_front();
                if (m_axis_tdata[11:0] !== want.row)
                    report_mismatch($sformatf("out_row %0d, want %0d",
                                              m_axis_tdata[11:0], want.row));
                if (m_axis_tdata[23:12] !== want.col)
                    report_mismatch($sformatf("out_col %0d, want %0d",
                                              m_axis_tdata[23:12], want.col));
                if (m_axis_tuser !== want.cfg_err)
                    report_mismatch($sformatf("config_error %0b, want %0b",
                                              m_axis_tuser, want.cfg_err));
            end
        end
    end

    // Starts and ends at a falling edge; valid stays up for a back-to-back word
    task automatic send_word(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, row};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_maps.push_back(swizzle_position(row, col));
        @(negedge clk);
    endtask

    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for every pending word, then let the pipeline settle
    task automatic wait_drained();
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            REG_NUM_COLS:   tile_cols  = value[12:0];
            REG_ELEM_BYTES: elem_shift = value[1:0];
            REG_GRANULE:    gran_shift = value[2:0];
            REG_STRIDE:     strd_shift = value[3:0];
            REG_LINE:       line_shift = value[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config(int cols, int ebl, int gran, int stride, int line);
        write_reg(REG_NUM_COLS, cols);
        write_reg(REG_ELEM_BYTES, ebl);
        write_reg(REG_GRANULE, gran);
        write_reg(REG_STRIDE, stride);
        write_reg(REG_LINE, line);
    endtask

    task automatic test_reset_defaults();
        send_word(12'd0, 12'd0);
        send_word(12'd1, 12'd5);
        send_word(12'd4095, 12'd63);
        send_word(12'd4095, 12'd4095);
        send_word(12'd37, 12'd17);
        end_stream();
        wait_drained();
    endtask

    task automatic test_column_extremes();
        // zero column count acts as one column; rows past range saturate
        load_config(0, 0, 4, 5, 7);
        send_word(12'd4095, 12'd4095);
        send_word(12'd3, 12'd0);
        end_stream();
        wait_drained();
        // oversized column count saturates, widest elements
        load_config(8191, 3, 7, 8, 8);
        send_word(12'd4095, 12'd4095);
        send_word(12'd0, 12'd4095);
        send_word(12'd1, 12'd0);
        end_stream();
        wait_drained();
        // column past num_cols spills onto later rows
        load_config(1, 2, 4, 8, 7);
        send_word(12'd2, 12'd4095);
        send_word(12'd0, 12'd2048);
        end_stream();
        wait_drained();
    endtask

    task automatic test_stride_below_granule();
        load_config(100, 1, 7, 5, 8);
        send_word(12'd5, 12'd7);
        send_word(12'd4095, 12'd4095);
        end_stream();
        wait_drained();
        // out-of-range shifts: huge line and stride
        load_config(4096, 3, 7, 15, 15);
        send_word(12'd4095, 12'd4095);
        send_word(12'd1234, 12'd567);
        end_stream();
        wait_drained();
        load_config(33, 0, 0, 0, 0);
        send_word(12'd77, 12'd31);
        send_word(12'd4095, 12'd32);
        end_stream();
        wait_drained();
    endtask

    task automatic test_unknown_index();
        load_config(48, 1, 5, 7, 8);
        for (int i = int'(REG_LINE) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(i[CFG_IDX_W-1:0], 13'h1FFF);
        send_word(12'd10, 12'd47);
        send_word(12'd2000, 12'd3);
        end_stream();
        wait_drained();
    endtask

    task automatic pick_random_config(int phase);
        int cols, ebl, gran, stride, line;
        cols   = $urandom_range(1, 4096);
        ebl    = $urandom_range(0, 3);
        gran   = $urandom_range(4, 7);
        stride = $urandom_range(5, 8);
        line   = $urandom_range(7, 8);
        if ($urandom_range(9) < 2)
            cols = 1 << $urandom_range(0, 12);
        if ($urandom_range(9) < 2)
            cols = $urandom_range(0, 8191);
        if ($urandom_range(9) == 0)
            gran = $urandom_range(0, 7);
        if ($urandom_range(9) == 0)
            stride = $urandom_range(0, 15);
        if ($urandom_range(9) == 0)
            line = $urandom_range(0, 15);
        if ($urandom_range(3) == 0)
            cols = $urandom_range(1, 16);
        // first phases pin the extremes of the nominal ranges
        if (phase == 0)
            load_config(1, 0, 4, 5, 7);
        else if (phase == 1)
            load_config(4096, 3, 7, 8, 8);
        else
            load_config(cols, ebl, gran, stride, line);
    endtask

    task automatic test_random_mapping();
        int span;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_random_config(phase);
            // a long stretch with no idling on either side
            src_idle_pct  = (phase >= 6 && phase < 10) ? 0 : 25;
            sink_idle_pct = src_idle_pct;
            span = int'(clamp_cols(tile_cols));
            if (span > 4096)
                span = 4096;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(9) < 4)
                    row = ROW_W'($urandom_range(0, 63));
                else
                    row = ROW_W'($urandom_range(0, 4095));
                if ($urandom_range(3) == 0)
                    col = COL_W'($urandom_range(0, 4095));
                else
                    col = COL_W'($urandom_range(0, span - 1));
                send_word(row, col);
            end
            end_stream();
            wait_drained();
        end
        src_idle_pct  = 25;
        sink_idle_pct = 25;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_column_extremes();
        test_stride_below_granule();
        test_unknown_index();
        test_random_mapping();
        wait_drained();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
